[rtl/tvp_pkg.sv]
// Shared types and constants for the trapezoid velocity profiler.
// Holds profile and phase codes, controller states and the controller/datapath link.
// Depends on nothing.
package tvp_pkg;

    // Default widths of the length and step-count values.
    localparam int LENGTH_BITS_DEF = 40;
    localparam int STEP_BITS_DEF   = 20;

    // Fixed widths of the feed, the acceleration register and the codes.
    localparam int FEED_W   = 32;
    localparam int ACCEL_W  = 32;
    localparam int MUL_B_W  = 33;
    localparam int PROD_W   = 64;
    localparam int ADDR_W   = 3;
    localparam int DATA_W   = 32;

    // Register map: the index is paddr[ADDR_W-1].
    localparam logic                ACCEL_INDEX = 1'b0;
    localparam logic [ACCEL_W-1:0]  ACCEL_RESET = 32'd65536;

    // Request kinds.
    localparam logic ACTION_PLAN = 1'b0;

    typedef enum logic [2:0] {
        KIND_NONE  = 3'd0,
        KIND_ONE   = 3'd1,
        KIND_CONST = 3'd2,
        KIND_TRI   = 3'd3,
        KIND_TRAP  = 3'd4
    } kind_t;

    typedef enum logic [2:0] {
        PH_IDLE  = 3'd0,
        PH_ACCEL = 3'd1,
        PH_CONST = 3'd2,
        PH_PEAK  = 3'd3,
        PH_DECEL = 3'd4,
        PH_END   = 3'd5
    } phase_t;

    // Datapath operations issued by the controller, one per cycle.
    typedef enum logic [4:0] {
        OP_NOP,
        OP_LOAD,
        OP_ONE,
        OP_CONST,
        OP_DIV_LF,
        OP_DIV_FA,
        OP_DIV_RF,
        OP_TAKE_N,
        OP_TAKE_CRUISE,
        OP_MUL_XA,
        OP_MUL_TX1,
        OP_MUL_CF,
        OP_MUL_AK1,
        OP_MUL_AD,
        OP_SUB_EXTRA,
        OP_EXTRA_LEN,
        OP_TRI_INIT,
        OP_TRI_MID,
        OP_TRI_STEP,
        OP_TRI_K,
        OP_TRI_ADJ,
        OP_TRI_PEAK,
        OP_TRAP_INIT,
        OP_FINISH,
        OP_TICK_MUL,
        OP_TICK_APPLY
    } dp_op_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_CHOOSE,
        S_DIV_LF,
        S_DIV_WAIT_CR,
        S_TAKE_CR,
        S_MUL_CF,
        S_SUB_EXTRA,
        S_WAIT_FA,
        S_TAKE_N,
        S_FULL_XA,
        S_FULL_TX,
        S_CLASSIFY,
        S_TRI_TEST,
        S_TRI_XA,
        S_TRI_TX,
        S_TRI_STEP,
        S_K_XA,
        S_K_TX,
        S_K_EXTRA,
        S_K_MUL1,
        S_K_ADJ,
        S_K_MULD,
        S_K_PEAK,
        S_TRAP_XA,
        S_TRAP_TX,
        S_TRAP_REST,
        S_DIV_RF,
        S_FINISH,
        S_TICK_MUL,
        S_TICK_APPLY,
        S_DONE
    } ctrl_state_t;

    typedef struct packed {
        dp_op_t op;
        logic   load_out;
    } dp_cmd_t;

    typedef struct packed {
        logic len_le_a;
        logic a_ge_feed;
        logic feed_zero;
        logic len_le_prod;
        logic lo_lt_hi;
        logic div_busy;
    } dp_status_t;

endpackage

[rtl/trapezoid_velocity_profiler_core.sv]
// Tick request: states TICK_MUL, TICK_APPLY, then DONE loads the result register; a
// new request is taken only in idle. Plan request: one step or zero feed goes straight
// to FINISH, constant feed runs one division, a trapezoid two, a triangle one and up to
// 32 search rounds on the shared multiplier; the divider gives one quotient bit per cycle
// over DIV_W bits (40 by default). The result register frees the input side while a
// result waits. Reset (rst_n low, async) clears control state; accel_reg gets 65536.
module trapezoid_velocity_profiler_core #(
    parameter int LENGTH_BITS = tvp_pkg::LENGTH_BITS_DEF,
    parameter int STEP_BITS   = tvp_pkg::STEP_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [tvp_pkg::ADDR_W-1:0]    paddr,
    input  logic [tvp_pkg::DATA_W-1:0]    pwdata,
    output logic [tvp_pkg::DATA_W-1:0]    prdata,
    output logic                          pready,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          action,
    input  logic [LENGTH_BITS-1:0]        block_length,
    input  logic [tvp_pkg::FEED_W-1:0]    feed_per_cycle,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [LENGTH_BITS-1:0]        displacement,
    output logic [2:0]                    profile_kind,
    output logic [2:0]                    phase,
    output logic                          finished
);

    logic [tvp_pkg::ACCEL_W-1:0] accel_reg;
    logic                        accel_sel;
    tvp_pkg::dp_cmd_t            cmd;
    tvp_pkg::dp_status_t         st;

    // Configuration register, written on the access cycle.
    assign pready    = 1'b1;
    assign accel_sel = paddr[tvp_pkg::ADDR_W-1] == tvp_pkg::ACCEL_INDEX;
    assign prdata    = accel_sel ? accel_reg : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            accel_reg <= tvp_pkg::ACCEL_RESET;
        end
        else if (psel && penable && pwrite && pready && accel_sel)
        begin
            accel_reg <= pwdata;
        end
    end

    // Controller.
    tvp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .action    (action),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .st        (st),
        .cmd       (cmd)
    );

    // Datapath.
    tvp_datapath #(
        .LENGTH_BITS (LENGTH_BITS),
        .STEP_BITS   (STEP_BITS)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .st             (st),
        .accel          (accel_reg),
        .block_length   (block_length),
        .feed_per_cycle (feed_per_cycle),
        .displacement   (displacement),
        .profile_kind   (profile_kind),
        .phase          (phase),
        .finished       (finished)
    );

endmodule

[rtl/tvp_div.sv]
// Restoring divider, one quotient bit per cycle, for the profiler datapath.
// Depends on tvp_pkg for the divisor width.
module tvp_div #(
    parameter int DIV_W = 40
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [DIV_W-1:0]          dividend,
    input  logic [tvp_pkg::FEED_W-1:0] divisor,
    output logic                      busy,
    output logic [DIV_W-1:0]          quotient
);

    localparam int CNT_W = $clog2(DIV_W + 1);
    localparam int REM_W = tvp_pkg::FEED_W + 1;

    logic [CNT_W-1:0]              cnt_reg, cnt_next;
    logic [DIV_W-1:0]              quo_reg, quo_next;
    logic [REM_W-1:0]              rem_reg, rem_next;
    logic [tvp_pkg::FEED_W-1:0]    dsr_reg, dsr_next;
    logic [REM_W-1:0]              rem_shift;
    logic                          fits;

    // One shift-and-subtract step per cycle while the count runs.
    always_comb
    begin
        rem_shift = {rem_reg[REM_W-2:0], quo_reg[DIV_W-1]};
        fits      = rem_shift >= {1'b0, dsr_reg};
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        if (start)
        begin
            cnt_next = CNT_W'(DIV_W);
            quo_next = dividend;
            rem_next = '0;
            dsr_next = divisor;
        end
        else if (cnt_reg != '0)
        begin
            cnt_next = cnt_reg - 1'b1;
            rem_next = fits ? (rem_shift - {1'b0, dsr_reg}) : rem_shift;
            quo_next = {quo_reg[DIV_W-2:0], fits};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign busy     = cnt_reg != '0;
    assign quotient = quo_reg;

endmodule

[rtl/tvp_datapath.sv]
// Datapath of the profiler: profile state, shared multiplier, divider and output register.
// Depends on tvp_pkg and tvp_div; driven by operations from tvp_ctrl.
module tvp_datapath #(
    parameter int LENGTH_BITS = tvp_pkg::LENGTH_BITS_DEF,
    parameter int STEP_BITS   = tvp_pkg::STEP_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  tvp_pkg::dp_cmd_t            cmd,
    output tvp_pkg::dp_status_t         st,
    input  logic [tvp_pkg::ACCEL_W-1:0] accel,
    input  logic [LENGTH_BITS-1:0]      block_length,
    input  logic [tvp_pkg::FEED_W-1:0]  feed_per_cycle,
    output logic [LENGTH_BITS-1:0]      displacement,
    output logic [2:0]                  profile_kind,
    output logic [2:0]                  phase,
    output logic                        finished
);

    localparam int DIV_W = (LENGTH_BITS > tvp_pkg::FEED_W) ? LENGTH_BITS : tvp_pkg::FEED_W;
    localparam int FW    = tvp_pkg::FEED_W;
    localparam int PW    = tvp_pkg::PROD_W;
    localparam int BW    = tvp_pkg::MUL_B_W;
    localparam logic [PW-1:0] LEN_MAX64  = {PW{1'b1}} >> (PW - LENGTH_BITS);
    localparam logic [PW-1:0] STEP_MAX64 = {PW{1'b1}} >> (PW - STEP_BITS);
    localparam logic [STEP_BITS-1:0] STEP_MAX = '1;

    function automatic logic [STEP_BITS-1:0] clamp_step(input logic [PW-1:0] v);
        logic [STEP_BITS-1:0] r;
        r = (v > STEP_MAX64) ? STEP_MAX : v[STEP_BITS-1:0];
        return r;
    endfunction

    function automatic logic [LENGTH_BITS-1:0] clamp_len(input logic [PW-1:0] v);
        logic [LENGTH_BITS-1:0] r;
        r = (v > LEN_MAX64) ? LEN_MAX64[LENGTH_BITS-1:0] : v[LENGTH_BITS-1:0];
        return r;
    endfunction

    function automatic logic [STEP_BITS-1:0] sat_inc(input logic [STEP_BITS-1:0] c);
        logic [STEP_BITS-1:0] r;
        r = (c == STEP_MAX) ? c : c + 1'b1;
        return r;
    endfunction

    // Profile state.
    logic [LENGTH_BITS-1:0] len_reg, len_next;
    logic [FW-1:0]          feed_reg, feed_next;
    logic [FW-1:0]          lo_reg, lo_next;
    logic [FW-1:0]          hi_reg, hi_next;
    logic [FW-1:0]          x_reg, x_next;
    logic [PW-1:0]          prod_reg, prod_next;
    logic [LENGTH_BITS-1:0] extra_reg, extra_next;
    logic [LENGTH_BITS-1:0] peak_reg, peak_next;
    logic [LENGTH_BITS-1:0] disp_reg, disp_next;
    logic [STEP_BITS-1:0]   accel_steps_reg, accel_steps_next;
    logic [STEP_BITS-1:0]   decel_steps_reg, decel_steps_next;
    logic [STEP_BITS-1:0]   cruise_steps_reg, cruise_steps_next;
    logic [STEP_BITS-1:0]   accel_cnt_reg, accel_cnt_next;
    logic [STEP_BITS-1:0]   decel_cnt_reg, decel_cnt_next;
    logic [STEP_BITS-1:0]   feed_cnt_reg, feed_cnt_next;
    tvp_pkg::kind_t         kind_reg, kind_next;
    tvp_pkg::phase_t        phase_reg, phase_next;
    logic                   pending_reg, pending_next;
    logic                   done_reg, done_next;

    // Output register.
    logic [LENGTH_BITS-1:0] out_disp_reg;
    logic [2:0]             out_kind_reg;
    logic [2:0]             out_phase_reg;
    logic                   out_done_reg;

    // Shared arithmetic.
    logic [FW-1:0]          a_eff;
    logic [FW-1:0]          mul_a;
    logic [BW-1:0]          mul_b;
    logic [FW+BW-1:0]       mul_full;
    logic [STEP_BITS-1:0]   left_steps;
    logic [STEP_BITS-1:0]   accel_inc;
    logic [BW-1:0]          span;
    logic [FW-1:0]          mid;
    logic [PW-1:0]          len64;
    logic [PW-1:0]          extra64;
    logic [PW-1:0]          tick_d;
    logic [STEP_BITS-1:0]   step_tmp;

    // Divider hookup.
    logic                   div_start;
    logic [DIV_W-1:0]       div_dividend;
    logic [FW-1:0]          div_divisor;
    logic                   div_busy;
    logic [DIV_W-1:0]       div_quot;

    tvp_div #(
        .DIV_W (DIV_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .busy     (div_busy),
        .quotient (div_quot)
    );

    // A zero acceleration register behaves as one.
    assign a_eff      = (accel == '0) ? FW'(1) : accel;
    assign len64      = PW'(len_reg);
    assign extra64    = PW'(extra_reg);
    assign accel_inc  = sat_inc(accel_cnt_reg);
    assign left_steps = (decel_steps_reg > decel_cnt_reg) ? (decel_steps_reg - decel_cnt_reg) : '0;
    assign span       = {1'b0, hi_reg} - {1'b0, lo_reg} + BW'(1);
    assign mid        = lo_reg + span[BW-1:1];

    // Multiplier operand selection.
    always_comb
    begin
        mul_a = a_eff;
        mul_b = '0;
        case (cmd.op)
            tvp_pkg::OP_MUL_XA:
            begin
                mul_a = x_reg;
                mul_b = BW'(a_eff);
            end
            tvp_pkg::OP_MUL_TX1:
            begin
                mul_a = prod_reg[FW-1:0];
                mul_b = BW'(x_reg) + BW'(1);
            end
            tvp_pkg::OP_MUL_CF:
            begin
                mul_a = feed_reg;
                mul_b = BW'(cruise_steps_reg);
            end
            tvp_pkg::OP_MUL_AK1:
            begin
                mul_b = BW'(decel_steps_reg) + BW'(1);
            end
            tvp_pkg::OP_MUL_AD:
            begin
                mul_b = BW'(decel_steps_reg);
            end
            tvp_pkg::OP_TICK_MUL:
            begin
                mul_b = (phase_reg == tvp_pkg::PH_ACCEL) ? BW'(accel_inc) : BW'(left_steps);
            end
            default:
            begin
                mul_b = '0;
            end
        endcase
    end

    assign mul_full = {{BW{1'b0}}, mul_a} * {{FW{1'b0}}, mul_b};

    // Divider operand selection.
    always_comb
    begin
        div_start    = 1'b0;
        div_dividend = DIV_W'(len_reg);
        div_divisor  = feed_reg;
        case (cmd.op)
            tvp_pkg::OP_DIV_LF:
            begin
                div_start = 1'b1;
            end
            tvp_pkg::OP_DIV_FA:
            begin
                div_start    = 1'b1;
                div_dividend = DIV_W'(feed_reg);
                div_divisor  = a_eff;
            end
            tvp_pkg::OP_DIV_RF:
            begin
                div_start    = 1'b1;
                div_dividend = DIV_W'(extra_reg);
            end
            default:
            begin
                div_start = 1'b0;
            end
        endcase
    end

    // Next-state logic of the profile state for each operation.
    always_comb
    begin
        len_next          = len_reg;
        feed_next         = feed_reg;
        lo_next           = lo_reg;
        hi_next           = hi_reg;
        x_next            = x_reg;
        prod_next         = prod_reg;
        extra_next        = extra_reg;
        peak_next         = peak_reg;
        disp_next         = disp_reg;
        accel_steps_next  = accel_steps_reg;
        decel_steps_next  = decel_steps_reg;
        cruise_steps_next = cruise_steps_reg;
        accel_cnt_next    = accel_cnt_reg;
        decel_cnt_next    = decel_cnt_reg;
        feed_cnt_next     = feed_cnt_reg;
        kind_next         = kind_reg;
        phase_next        = phase_reg;
        pending_next      = pending_reg;
        done_next         = done_reg;
        tick_d            = '0;
        step_tmp          = '0;
        case (cmd.op)
            tvp_pkg::OP_LOAD:
            begin
                len_next          = block_length;
                feed_next         = feed_per_cycle;
                extra_next        = '0;
                peak_next         = '0;
                disp_next         = '0;
                accel_steps_next  = '0;
                decel_steps_next  = '0;
                cruise_steps_next = '0;
                accel_cnt_next    = '0;
                decel_cnt_next    = '0;
                feed_cnt_next     = '0;
                kind_next         = tvp_pkg::KIND_NONE;
                phase_next        = tvp_pkg::PH_IDLE;
                pending_next      = 1'b0;
                done_next         = 1'b0;
            end
            tvp_pkg::OP_ONE:
            begin
                kind_next  = tvp_pkg::KIND_ONE;
                peak_next  = len_reg;
                phase_next = tvp_pkg::PH_IDLE;
            end
            tvp_pkg::OP_CONST:
            begin
                kind_next  = tvp_pkg::KIND_CONST;
                phase_next = tvp_pkg::PH_CONST;
                extra_next = len_reg;
            end
            tvp_pkg::OP_TAKE_N:
            begin
                lo_next = '0;
                hi_next = div_quot[FW-1:0];
                x_next  = div_quot[FW-1:0];
            end
            tvp_pkg::OP_TAKE_CRUISE:
            begin
                cruise_steps_next = clamp_step(PW'(div_quot));
            end
            tvp_pkg::OP_MUL_XA, tvp_pkg::OP_MUL_TX1, tvp_pkg::OP_MUL_CF,
            tvp_pkg::OP_MUL_AK1, tvp_pkg::OP_MUL_AD, tvp_pkg::OP_TICK_MUL:
            begin
                prod_next = mul_full[PW-1:0];
            end
            tvp_pkg::OP_SUB_EXTRA:
            begin
                extra_next = extra_reg - prod_reg[LENGTH_BITS-1:0];
            end
            tvp_pkg::OP_EXTRA_LEN:
            begin
                extra_next = len_reg - prod_reg[LENGTH_BITS-1:0];
            end
            tvp_pkg::OP_TRI_INIT:
            begin
                kind_next  = tvp_pkg::KIND_TRI;
                phase_next = tvp_pkg::PH_ACCEL;
            end
            tvp_pkg::OP_TRI_MID:
            begin
                x_next = mid;
            end
            tvp_pkg::OP_TRI_STEP:
            begin
                // Keep the largest count whose ramp stays short of the length.
                if (prod_reg < len64)
                begin
                    lo_next = x_reg;
                end
                else
                begin
                    hi_next = x_reg - 1'b1;
                end
            end
            tvp_pkg::OP_TRI_K:
            begin
                step_tmp         = clamp_step(PW'(lo_reg));
                accel_steps_next = step_tmp;
                decel_steps_next = step_tmp;
                x_next           = FW'(step_tmp);
            end
            tvp_pkg::OP_TRI_ADJ:
            begin
                if (extra64 >= prod_reg)
                begin
                    accel_steps_next = clamp_step(PW'(decel_steps_reg) + PW'(1));
                    extra_next       = extra_reg - prod_reg[LENGTH_BITS-1:0];
                end
            end
            tvp_pkg::OP_TRI_PEAK:
            begin
                if (extra64 >= prod_reg)
                begin
                    peak_next  = extra_reg;
                    extra_next = '0;
                end
            end
            tvp_pkg::OP_TRAP_INIT:
            begin
                kind_next        = tvp_pkg::KIND_TRAP;
                phase_next       = tvp_pkg::PH_ACCEL;
                step_tmp         = clamp_step(PW'(hi_reg));
                accel_steps_next = step_tmp;
                decel_steps_next = step_tmp;
                x_next           = FW'(step_tmp);
            end
            tvp_pkg::OP_FINISH:
            begin
                pending_next = extra_reg != '0;
            end
            tvp_pkg::OP_TICK_APPLY:
            begin
                // One interpolation tick: walk the phases.
                case (kind_reg)
                    tvp_pkg::KIND_NONE:
                    begin
                        tick_d = '0;
                    end
                    tvp_pkg::KIND_ONE:
                    begin
                        if (phase_reg != tvp_pkg::PH_END)
                        begin
                            tick_d     = PW'(peak_reg);
                            phase_next = tvp_pkg::PH_END;
                        end
                        done_next = 1'b1;
                    end
                    default:
                    begin
                        case (phase_reg)
                            tvp_pkg::PH_ACCEL:
                            begin
                                accel_cnt_next = accel_inc;
                                tick_d         = prod_reg;
                                if (accel_inc >= accel_steps_reg)
                                begin
                                    if (peak_reg != '0)
                                    begin
                                        phase_next = tvp_pkg::PH_PEAK;
                                    end
                                    else if (cruise_steps_reg == '0)
                                    begin
                                        phase_next = tvp_pkg::PH_DECEL;
                                    end
                                    else
                                    begin
                                        phase_next = tvp_pkg::PH_CONST;
                                    end
                                end
                            end
                            tvp_pkg::PH_CONST:
                            begin
                                step_tmp      = sat_inc(feed_cnt_reg);
                                feed_cnt_next = step_tmp;
                                tick_d        = PW'(feed_reg);
                                if (step_tmp >= cruise_steps_reg)
                                begin
                                    phase_next = tvp_pkg::PH_DECEL;
                                end
                            end
                            tvp_pkg::PH_PEAK:
                            begin
                                tick_d     = PW'(peak_reg);
                                phase_next = tvp_pkg::PH_DECEL;
                            end
                            tvp_pkg::PH_DECEL:
                            begin
                                // The remainder goes in once it is larger than the ramp step.
                                if (pending_reg && (extra64 > prod_reg))
                                begin
                                    tick_d       = extra64;
                                    pending_next = 1'b0;
                                end
                                else
                                begin
                                    tick_d         = prod_reg;
                                    step_tmp       = sat_inc(decel_cnt_reg);
                                    decel_cnt_next = step_tmp;
                                    if (step_tmp >= decel_steps_reg)
                                    begin
                                        phase_next = tvp_pkg::PH_END;
                                    end
                                end
                            end
                            tvp_pkg::PH_END:
                            begin
                                tick_d    = '0;
                                done_next = 1'b1;
                            end
                            default:
                            begin
                                tick_d = '0;
                            end
                        endcase
                    end
                endcase
                disp_next = clamp_len(tick_d);
            end
            default:
            begin
                tick_d = '0;
            end
        endcase
    end

    // Control-like state is cleared at reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kind_reg         <= tvp_pkg::KIND_NONE;
            phase_reg        <= tvp_pkg::PH_IDLE;
            pending_reg      <= 1'b0;
            done_reg         <= 1'b0;
            accel_cnt_reg    <= '0;
            decel_cnt_reg    <= '0;
            feed_cnt_reg     <= '0;
            accel_steps_reg  <= '0;
            decel_steps_reg  <= '0;
            cruise_steps_reg <= '0;
            peak_reg         <= '0;
            extra_reg        <= '0;
            feed_reg         <= '0;
        end
        else
        begin
            kind_reg         <= kind_next;
            phase_reg        <= phase_next;
            pending_reg      <= pending_next;
            done_reg         <= done_next;
            accel_cnt_reg    <= accel_cnt_next;
            decel_cnt_reg    <= decel_cnt_next;
            feed_cnt_reg     <= feed_cnt_next;
            accel_steps_reg  <= accel_steps_next;
            decel_steps_reg  <= decel_steps_next;
            cruise_steps_reg <= cruise_steps_next;
            peak_reg         <= peak_next;
            extra_reg        <= extra_next;
            feed_reg         <= feed_next;
        end
    end

    // Working registers of the planning sequence.
    always_ff @(posedge clk)
    begin
        len_reg  <= len_next;
        lo_reg   <= lo_next;
        hi_reg   <= hi_next;
        x_reg    <= x_next;
        prod_reg <= prod_next;
        disp_reg <= disp_next;
    end

    // Result register, loaded when the controller hands a result out.
    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_disp_reg  <= disp_reg;
            out_kind_reg  <= kind_reg;
            out_phase_reg <= phase_reg;
            out_done_reg  <= done_reg;
        end
    end

    assign displacement = out_disp_reg;
    assign profile_kind = out_kind_reg;
    assign phase        = out_phase_reg;
    assign finished     = out_done_reg;

    // Status toward the controller.
    assign st.len_le_a    = len64 <= PW'(a_eff);
    assign st.a_ge_feed   = a_eff >= feed_reg;
    assign st.feed_zero   = feed_reg == '0;
    assign st.len_le_prod = len64 <= prod_reg;
    assign st.lo_lt_hi    = lo_reg < hi_reg;
    assign st.div_busy    = div_busy;

    // A new division never starts on top of a running one.
    assert property (@(posedge clk) disable iff (!rst_n) div_start |-> !div_busy)
        else $error("divider restarted while busy");

    // A one-step profile only ever sits in idle or end.
    assert property (@(posedge clk) disable iff (!rst_n)
        kind_reg == tvp_pkg::KIND_ONE |->
            (phase_reg == tvp_pkg::PH_IDLE || phase_reg == tvp_pkg::PH_END))
        else $error("one-step profile in a ramp phase");

endmodule

[rtl/tvp_ctrl.sv]
// Controller of the profiler: sequences planning and ticks over the datapath.
// Depends on tvp_pkg for the state, operation and status types.
module tvp_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                action,
    output logic                out_valid,
    input  logic                out_ready,
    input  tvp_pkg::dp_status_t st,
    output tvp_pkg::dp_cmd_t    cmd
);

    tvp_pkg::ctrl_state_t state_reg, state_next;
    logic                 out_valid_reg, out_valid_next;
    logic                 accept;

    assign in_ready = state_reg == tvp_pkg::S_IDLE;
    assign accept   = in_valid && in_ready;

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            tvp_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    state_next = (action == tvp_pkg::ACTION_PLAN) ? tvp_pkg::S_CHOOSE
                                                                  : tvp_pkg::S_TICK_MUL;
                end
            end
            tvp_pkg::S_CHOOSE:
            begin
                if (st.len_le_a)
                begin
                    state_next = tvp_pkg::S_FINISH;
                end
                else if (st.a_ge_feed)
                begin
                    state_next = st.feed_zero ? tvp_pkg::S_FINISH : tvp_pkg::S_DIV_LF;
                end
                else
                begin
                    state_next = tvp_pkg::S_WAIT_FA;
                end
            end
            tvp_pkg::S_DIV_LF:      state_next = tvp_pkg::S_DIV_WAIT_CR;
            tvp_pkg::S_DIV_WAIT_CR:
            begin
                if (!st.div_busy)
                begin
                    state_next = tvp_pkg::S_TAKE_CR;
                end
            end
            tvp_pkg::S_TAKE_CR:     state_next = tvp_pkg::S_MUL_CF;
            tvp_pkg::S_MUL_CF:      state_next = tvp_pkg::S_SUB_EXTRA;
            tvp_pkg::S_SUB_EXTRA:   state_next = tvp_pkg::S_FINISH;
            tvp_pkg::S_WAIT_FA:
            begin
                if (!st.div_busy)
                begin
                    state_next = tvp_pkg::S_TAKE_N;
                end
            end
            tvp_pkg::S_TAKE_N:      state_next = tvp_pkg::S_FULL_XA;
            tvp_pkg::S_FULL_XA:     state_next = tvp_pkg::S_FULL_TX;
            tvp_pkg::S_FULL_TX:     state_next = tvp_pkg::S_CLASSIFY;
            tvp_pkg::S_CLASSIFY:
            begin
                state_next = st.len_le_prod ? tvp_pkg::S_TRI_TEST : tvp_pkg::S_TRAP_XA;
            end
            tvp_pkg::S_TRI_TEST:
            begin
                state_next = st.lo_lt_hi ? tvp_pkg::S_TRI_XA : tvp_pkg::S_K_XA;
            end
            tvp_pkg::S_TRI_XA:      state_next = tvp_pkg::S_TRI_TX;
            tvp_pkg::S_TRI_TX:      state_next = tvp_pkg::S_TRI_STEP;
            tvp_pkg::S_TRI_STEP:    state_next = tvp_pkg::S_TRI_TEST;
            tvp_pkg::S_K_XA:        state_next = tvp_pkg::S_K_TX;
            tvp_pkg::S_K_TX:        state_next = tvp_pkg::S_K_EXTRA;
            tvp_pkg::S_K_EXTRA:     state_next = tvp_pkg::S_K_MUL1;
            tvp_pkg::S_K_MUL1:      state_next = tvp_pkg::S_K_ADJ;
            tvp_pkg::S_K_ADJ:       state_next = tvp_pkg::S_K_MULD;
            tvp_pkg::S_K_MULD:      state_next = tvp_pkg::S_K_PEAK;
            tvp_pkg::S_K_PEAK:      state_next = tvp_pkg::S_FINISH;
            tvp_pkg::S_TRAP_XA:     state_next = tvp_pkg::S_TRAP_TX;
            tvp_pkg::S_TRAP_TX:     state_next = tvp_pkg::S_TRAP_REST;
            tvp_pkg::S_TRAP_REST:   state_next = tvp_pkg::S_DIV_RF;
            tvp_pkg::S_DIV_RF:      state_next = tvp_pkg::S_DIV_WAIT_CR;
            tvp_pkg::S_FINISH:      state_next = tvp_pkg::S_DONE;
            tvp_pkg::S_TICK_MUL:    state_next = tvp_pkg::S_TICK_APPLY;
            tvp_pkg::S_TICK_APPLY:  state_next = tvp_pkg::S_DONE;
            tvp_pkg::S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    state_next = tvp_pkg::S_IDLE;
                end
            end
            default:                state_next = tvp_pkg::S_IDLE;
        endcase
    end

    // Output logic: one datapath operation per state.
    always_comb
    begin
        cmd.op       = tvp_pkg::OP_NOP;
        cmd.load_out = 1'b0;
        case (state_reg)
            tvp_pkg::S_IDLE:
            begin
                if (accept && (action == tvp_pkg::ACTION_PLAN))
                begin
                    cmd.op = tvp_pkg::OP_LOAD;
                end
            end
            tvp_pkg::S_CHOOSE:
            begin
                if (st.len_le_a)
                begin
                    cmd.op = tvp_pkg::OP_ONE;
                end
                else if (st.a_ge_feed)
                begin
                    cmd.op = tvp_pkg::OP_CONST;
                end
                else
                begin
                    cmd.op = tvp_pkg::OP_DIV_FA;
                end
            end
            tvp_pkg::S_DIV_LF:      cmd.op = tvp_pkg::OP_DIV_LF;
            tvp_pkg::S_TAKE_CR:     cmd.op = tvp_pkg::OP_TAKE_CRUISE;
            tvp_pkg::S_MUL_CF:      cmd.op = tvp_pkg::OP_MUL_CF;
            tvp_pkg::S_SUB_EXTRA:   cmd.op = tvp_pkg::OP_SUB_EXTRA;
            tvp_pkg::S_TAKE_N:      cmd.op = tvp_pkg::OP_TAKE_N;
            tvp_pkg::S_FULL_XA:     cmd.op = tvp_pkg::OP_MUL_XA;
            tvp_pkg::S_FULL_TX:     cmd.op = tvp_pkg::OP_MUL_TX1;
            tvp_pkg::S_CLASSIFY:
            begin
                cmd.op = st.len_le_prod ? tvp_pkg::OP_TRI_INIT : tvp_pkg::OP_TRAP_INIT;
            end
            tvp_pkg::S_TRI_TEST:
            begin
                cmd.op = st.lo_lt_hi ? tvp_pkg::OP_TRI_MID : tvp_pkg::OP_TRI_K;
            end
            tvp_pkg::S_TRI_XA:      cmd.op = tvp_pkg::OP_MUL_XA;
            tvp_pkg::S_TRI_TX:      cmd.op = tvp_pkg::OP_MUL_TX1;
            tvp_pkg::S_TRI_STEP:    cmd.op = tvp_pkg::OP_TRI_STEP;
            tvp_pkg::S_K_XA:        cmd.op = tvp_pkg::OP_MUL_XA;
            tvp_pkg::S_K_TX:        cmd.op = tvp_pkg::OP_MUL_TX1;
            tvp_pkg::S_K_EXTRA:     cmd.op = tvp_pkg::OP_EXTRA_LEN;
            tvp_pkg::S_K_MUL1:      cmd.op = tvp_pkg::OP_MUL_AK1;
            tvp_pkg::S_K_ADJ:       cmd.op = tvp_pkg::OP_TRI_ADJ;
            tvp_pkg::S_K_MULD:      cmd.op = tvp_pkg::OP_MUL_AD;
            tvp_pkg::S_K_PEAK:      cmd.op = tvp_pkg::OP_TRI_PEAK;
            tvp_pkg::S_TRAP_XA:     cmd.op = tvp_pkg::OP_MUL_XA;
            tvp_pkg::S_TRAP_TX:     cmd.op = tvp_pkg::OP_MUL_TX1;
            tvp_pkg::S_TRAP_REST:   cmd.op = tvp_pkg::OP_EXTRA_LEN;
            tvp_pkg::S_DIV_RF:      cmd.op = tvp_pkg::OP_DIV_RF;
            tvp_pkg::S_FINISH:      cmd.op = tvp_pkg::OP_FINISH;
            tvp_pkg::S_TICK_MUL:    cmd.op = tvp_pkg::OP_TICK_MUL;
            tvp_pkg::S_TICK_APPLY:  cmd.op = tvp_pkg::OP_TICK_APPLY;
            tvp_pkg::S_DONE:
            begin
                cmd.load_out = !out_valid_reg || out_ready;
            end
            default:                cmd.op = tvp_pkg::OP_NOP;
        endcase
    end

    // The result stays valid until it is taken.
    assign out_valid_next = cmd.load_out || (out_valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= tvp_pkg::S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

    // A result is never loaded over one that is still waiting.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> (!out_valid_reg || out_ready))
        else $error("result overwritten before it was taken");

    // Every result handed out comes back to idle in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |=> (state_reg == tvp_pkg::S_IDLE) && out_valid_reg)
        else $error("result hand-off did not complete");

endmodule
